>>> src/rmj_pkg.sv
package rmj_pkg;

	localparam int CFG_WIDTH = 32;
	// 0.0001 in Q0.32
	localparam logic [CFG_WIDTH-1:0] CFG_RESET = 32'd429497;

	// per-item flags that ride alongside the arithmetic
	typedef struct packed {
		logic valid;
		logic sx;
		logic sy;
		logic st;
		logic deg;
	} flags_t;

	localparam int FLAGS_WIDTH = $bits(flags_t);

endpackage

>>> src/radar_measurement_jacobian.sv
// Radar measurement Jacobian for one 2-D state (px, py, vx, vy) in signed fixed point.
// Pulse start with a state on the inputs and the six distinct Jacobian entries appear
// later, each for exactly one cycle with done high. busy never rises: a new item is
// taken every cycle, so one item per clock is the sustained rate, and the output is
// never held - the receiver must take every result the cycle it is shown. The latency
// is set by the range square root (one result bit per stage) followed by the long
// dividers (one quotient bit per stage). When px^2 + py^2 is zero or below
// min_range_squared, degenerate is high and all six entries are zero. Quotients
// truncate toward zero and saturate to the signed output range. Write
// min_range_squared only while no item is in flight; cfg_ready is always high.
module radar_measurement_jacobian #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [DATA_WIDTH-1:0]      pos_x,
	input  logic signed [DATA_WIDTH-1:0]      pos_y,
	input  logic signed [DATA_WIDTH-1:0]      vel_x,
	input  logic signed [DATA_WIDTH-1:0]      vel_y,
	output logic                              done,
	output logic signed [DATA_WIDTH-1:0]      range_by_px,
	output logic signed [DATA_WIDTH-1:0]      range_by_py,
	output logic signed [DATA_WIDTH-1:0]      bearing_by_px,
	output logic signed [DATA_WIDTH-1:0]      bearing_by_py,
	output logic signed [DATA_WIDTH-1:0]      rate_by_px,
	output logic signed [DATA_WIDTH-1:0]      rate_by_py,
	output logic                              degenerate,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rmj_pkg::CFG_WIDTH-1:0]     cfg_data
);

	localparam int W   = DATA_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int FW  = rmj_pkg::FLAGS_WIDTH;
	localparam int CW  = (2 * W > rmj_pkg::CFG_WIDTH) ? 2 * W : rmj_pkg::CFG_WIDTH;
	localparam int D1W = FW + 6 * W;
	localparam int D2W = FW + 5 * W;
	localparam int LAT = 7 + 2 * W;

	// never stalls; configuration is taken at once
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	logic [rmj_pkg::CFG_WIDTH-1:0] min_range_squared_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_range_squared_q <= rmj_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			min_range_squared_q <= cfg_data;
		end
	end

	// stage 1: split each input into sign and magnitude
	logic         valid_s1;
	logic         sx_s1, sy_s1, svx_s1, svy_s1;
	logic [W-1:0] mx_s1, my_s1, mvx_s1, mvy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		sx_s1  <= pos_x[W-1];
		sy_s1  <= pos_y[W-1];
		svx_s1 <= vel_x[W-1];
		svy_s1 <= vel_y[W-1];
		mx_s1  <= pos_x[W-1] ? (~pos_x + W'(1)) : pos_x;
		my_s1  <= pos_y[W-1] ? (~pos_y + W'(1)) : pos_y;
		mvx_s1 <= vel_x[W-1] ? (~vel_x + W'(1)) : vel_x;
		mvy_s1 <= vel_y[W-1] ? (~vel_y + W'(1)) : vel_y;
	end

	// stage 2: squares and cross products
	logic           valid_s2;
	logic           sx_s2, sy_s2, sa_s2, sb_s2;
	logic [W-1:0]   mx_s2, my_s2;
	logic [2*W-1:0] xx_s2, yy_s2, vxy_s2, vyx_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		sx_s2  <= sx_s1;
		sy_s2  <= sy_s1;
		sa_s2  <= svx_s1 ^ sy_s1;
		sb_s2  <= ~(svy_s1 ^ sx_s1);
		mx_s2  <= mx_s1;
		my_s2  <= my_s1;
		xx_s2  <= mx_s1 * mx_s1;
		yy_s2  <= my_s1 * my_s1;
		vxy_s2 <= mvx_s1 * my_s1;
		vyx_s2 <= mvy_s1 * mx_s1;
	end

	// stage 3: range squared and vx*py - vy*px in sign-magnitude form
	logic           valid_s3;
	logic           sx_s3, sy_s3, st_s3;
	logic [W-1:0]   mx_s3, my_s3;
	logic [2*W-1:0] rsq_s3, t_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		sx_s3  <= sx_s2;
		sy_s3  <= sy_s2;
		mx_s3  <= mx_s2;
		my_s3  <= my_s2;
		rsq_s3 <= xx_s2 + yy_s2;
		if (sa_s2 == sb_s2) begin
			t_s3  <= vxy_s2 + vyx_s2;
			st_s3 <= sa_s2;
		end else if (vxy_s2 >= vyx_s2) begin
			t_s3  <= vxy_s2 - vyx_s2;
			st_s3 <= sa_s2;
		end else begin
			t_s3  <= vyx_s2 - vxy_s2;
			st_s3 <= sb_s2;
		end
	end

	// zero range always counts as degenerate so no quotient by a zero divisor reaches the outputs
	rmj_pkg::flags_t flags_s3;

	always_comb begin
		flags_s3.valid = valid_s3;
		flags_s3.sx    = sx_s3;
		flags_s3.sy    = sy_s3;
		flags_s3.st    = st_s3;
		flags_s3.deg   = (rsq_s3 == '0) || (CW'(rsq_s3) < CW'(min_range_squared_q));
	end

	// stage 4: range from the square root; hold the rest alongside
	logic [W-1:0]    r_s4;
	logic [D1W-1:0]  side_s4;
	rmj_pkg::flags_t flags_s4;
	logic [W-1:0]    mx_s4, my_s4;
	logic [2*W-1:0]  rsq_s4, t_s4;

	rmj_sqrt_pipe #(.W(W)) u_sqrt (
		.clk  (clk),
		.rad  (rsq_s3),
		.root (r_s4)
	);

	rmj_delay #(.WIDTH(D1W), .DEPTH(W)) u_side1 (
		.clk    (clk),
		.arst_n (arst_n),
		.din    ({flags_s3, mx_s3, my_s3, rsq_s3, t_s3}),
		.dout   (side_s4)
	);

	assign {flags_s4, mx_s4, my_s4, rsq_s4, t_s4} = side_s4;

	// stage 5: wide products for the range-rate terms
	logic [3*W-1:0]  srr_s5, ny_s5, nx_s5;
	logic [D2W-1:0]  side_s5;
	rmj_pkg::flags_t flags_s5;
	logic [W-1:0]    mx_s5, my_s5, r_s5;
	logic [2*W-1:0]  rsq_s5;

	rmj_mul_wide #(.W(W)) u_mul_den (
		.clk (clk),
		.a   (r_s4),
		.b   (rsq_s4),
		.p   (srr_s5)
	);

	rmj_mul_wide #(.W(W)) u_mul_ny (
		.clk (clk),
		.a   (my_s4),
		.b   (t_s4),
		.p   (ny_s5)
	);

	rmj_mul_wide #(.W(W)) u_mul_nx (
		.clk (clk),
		.a   (mx_s4),
		.b   (t_s4),
		.p   (nx_s5)
	);

	rmj_delay #(.WIDTH(D2W), .DEPTH(2)) u_side2 (
		.clk    (clk),
		.arst_n (arst_n),
		.din    ({flags_s4, mx_s4, my_s4, rsq_s4, r_s4}),
		.dout   (side_s5)
	);

	assign {flags_s5, mx_s5, my_s5, rsq_s5, r_s5} = side_s5;

	// stage 6: six long divisions in parallel
	logic [W-1:0]    q_s6 [6];
	logic            o_s6 [6];
	rmj_pkg::flags_t flags_s6;

	rmj_div_pipe #(.NW(W + F), .DD(W), .QW(W)) u_div_rpx (
		.clk (clk), .num ({mx_s5, {F{1'b0}}}), .den (r_s5),
		.quo (q_s6[0]), .ovf (o_s6[0])
	);

	rmj_div_pipe #(.NW(W + F), .DD(W), .QW(W)) u_div_rpy (
		.clk (clk), .num ({my_s5, {F{1'b0}}}), .den (r_s5),
		.quo (q_s6[1]), .ovf (o_s6[1])
	);

	rmj_div_pipe #(.NW(W + 2 * F), .DD(2 * W), .QW(W)) u_div_bpx (
		.clk (clk), .num ({my_s5, {(2 * F){1'b0}}}), .den (rsq_s5),
		.quo (q_s6[2]), .ovf (o_s6[2])
	);

	rmj_div_pipe #(.NW(W + 2 * F), .DD(2 * W), .QW(W)) u_div_bpy (
		.clk (clk), .num ({mx_s5, {(2 * F){1'b0}}}), .den (rsq_s5),
		.quo (q_s6[3]), .ovf (o_s6[3])
	);

	rmj_div_pipe #(.NW(3 * W + F), .DD(3 * W), .QW(W)) u_div_qpx (
		.clk (clk), .num ({ny_s5, {F{1'b0}}}), .den (srr_s5),
		.quo (q_s6[4]), .ovf (o_s6[4])
	);

	rmj_div_pipe #(.NW(3 * W + F), .DD(3 * W), .QW(W)) u_div_qpy (
		.clk (clk), .num ({nx_s5, {F{1'b0}}}), .den (srr_s5),
		.quo (q_s6[5]), .ovf (o_s6[5])
	);

	rmj_delay #(.WIDTH(FW), .DEPTH(W + 1)) u_side3 (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (flags_s5),
		.dout   (flags_s6)
	);

	// clamp the magnitude to the signed range, then apply the sign
	function automatic logic [W-1:0] sat_sign(input logic [W-1:0] m, input logic ovf,
			input logic neg);
		logic [W-1:0] lim;
		logic [W-1:0] mm;
		lim = neg ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
		mm  = (ovf || (m > lim)) ? lim : m;
		return neg ? (~mm + W'(1)) : mm;
	endfunction

	// stage 7: output register, shown for one cycle
	logic         done_s7;
	logic         deg_s7;
	logic [W-1:0] res_s7 [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s7 <= 1'b0;
		end else begin
			done_s7 <= flags_s6.valid;
		end
	end

	always_ff @(posedge clk) begin
		deg_s7 <= flags_s6.deg;
		if (flags_s6.deg) begin
			for (int i = 0; i < 6; i++) res_s7[i] <= '0;
		end else begin
			res_s7[0] <= sat_sign(q_s6[0], o_s6[0], flags_s6.sx);
			res_s7[1] <= sat_sign(q_s6[1], o_s6[1], flags_s6.sy);
			res_s7[2] <= sat_sign(q_s6[2], o_s6[2], ~flags_s6.sy);
			res_s7[3] <= sat_sign(q_s6[3], o_s6[3], flags_s6.sx);
			res_s7[4] <= sat_sign(q_s6[4], o_s6[4], flags_s6.sy ^ flags_s6.st);
			res_s7[5] <= sat_sign(q_s6[5], o_s6[5], ~(flags_s6.sx ^ flags_s6.st));
		end
	end

	assign done          = done_s7;
	assign degenerate    = deg_s7;
	assign range_by_px   = res_s7[0];
	assign range_by_py   = res_s7[1];
	assign bearing_by_px = res_s7[2];
	assign bearing_by_py = res_s7[3];
	assign rate_by_px    = res_s7[4];
	assign rate_by_py    = res_s7[5];

`ifndef ASSERT_OFF
	// every result traces back to an earlier accepted item
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching accepted item");

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> (range_by_px == '0) && (range_by_py == '0) &&
			(bearing_by_px == '0) && (bearing_by_py == '0) &&
			(rate_by_px == '0) && (rate_by_py == '0))
		else $error("degenerate result carries non-zero entries");

	// px/r and px/r^2 share the sign of px
	a_sign_px: assert property (@(posedge clk) disable iff (!arst_n)
		done && !degenerate && (range_by_px != '0) && (bearing_by_py != '0) |->
			(range_by_px[W-1] == bearing_by_py[W-1]))
		else $error("sign mismatch between range and bearing terms in px");

	// py/r and -py/r^2 have opposite signs
	a_sign_py: assert property (@(posedge clk) disable iff (!arst_n)
		done && !degenerate && (range_by_py != '0) && (bearing_by_px != '0) |->
			(range_by_py[W-1] != bearing_by_px[W-1]))
		else $error("sign mismatch between range and bearing terms in py");
`endif

endmodule

>>> src/rmj_delay.sv
module rmj_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] line_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) line_q[i] <= '0;
		end else begin
			line_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) line_q[i] <= line_q[i-1];
		end
	end

	assign dout = line_q[DEPTH-1];

endmodule

>>> src/rmj_mul_wide.sv
module rmj_mul_wide #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic [W-1:0]   a,
	input  logic [2*W-1:0] b,
	output logic [3*W-1:0] p
);

	logic [2*W-1:0] plo_q;
	logic [2*W-1:0] phi_q;
	logic [3*W-1:0] p_q;

	// split the wide operand into two halves, then recombine
	always_ff @(posedge clk) begin
		plo_q <= a * b[W-1:0];
		phi_q <= a * b[2*W-1:W];
		p_q   <= {phi_q, {W{1'b0}}} + {{W{1'b0}}, plo_q};
	end

	assign p = p_q;

endmodule

>>> src/rmj_sqrt_pipe.sv
module rmj_sqrt_pipe #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic [2*W-1:0] rad,
	output logic [W-1:0]   root
);

	logic [W+1:0]   rem_q  [W];
	logic [W-1:0]   root_q [W];
	logic [2*W-1:0] rad_q  [W];

	// one result bit per stage, two radicand bits consumed per stage
	for (genvar i = 0; i < W; i++) begin : g_stage
		logic [W+1:0]   prev_rem;
		logic [W-1:0]   prev_root;
		logic [2*W-1:0] prev_rad;
		logic [W+1:0]   cur;
		logic [W+1:0]   trial;
		logic           ge;

		if (i == 0) begin : g_first
			assign prev_rem  = '0;
			assign prev_root = '0;
			assign prev_rad  = rad;
		end else begin : g_next
			assign prev_rem  = rem_q[i-1];
			assign prev_root = root_q[i-1];
			assign prev_rad  = rad_q[i-1];
		end

		always_comb begin
			cur   = {prev_rem[W-1:0], prev_rad[2*W-1 -: 2]};
			trial = {prev_root, 2'b01};
			ge    = (cur >= trial);
		end

		always_ff @(posedge clk) begin
			rem_q[i]  <= ge ? (cur - trial) : cur;
			root_q[i] <= {prev_root[W-2:0], ge};
		end

		if (i < W - 1) begin : g_shift
			always_ff @(posedge clk) begin
				rad_q[i] <= {prev_rad[2*W-3:0], 2'b00};
			end
		end else begin : g_tail
			always_ff @(posedge clk) begin
				rad_q[i] <= '0;
			end
		end
	end

	assign root = root_q[W-1];

endmodule

>>> src/rmj_div_pipe.sv
module rmj_div_pipe #(
	parameter int NW = 48,
	parameter int DD = 32,
	parameter int QW = 32
) (
	input  logic          clk,
	input  logic [NW-1:0] num,
	input  logic [DD-1:0] den,
	output logic [QW-1:0] quo,
	output logic          ovf
);

	localparam int HW = NW - QW;
	localparam int CW = (HW > DD) ? HW : DD;

	logic [DD-1:0] rem_q  [QW];
	logic [DD-1:0] den_q  [QW];
	logic [QW-1:0] low_q  [QW];
	logic [QW-1:0] quo_q  [1:QW];
	logic          ovf_q  [QW+1];

	// quotient wider than QW bits: flag and let the receiver saturate
	always_ff @(posedge clk) begin
		ovf_q[0] <= (CW'(num[NW-1:QW]) >= CW'(den));
		rem_q[0] <= DD'(num[NW-1:QW]);
		den_q[0] <= den;
		low_q[0] <= num[QW-1:0];
	end

	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [DD:0]   cur;
		logic [DD:0]   diff;
		logic          ge;
		logic [QW-1:0] prev_quo;

		if (k == 1) begin : g_first
			assign prev_quo = '0;
		end else begin : g_next
			assign prev_quo = quo_q[k-1];
		end

		always_comb begin
			cur  = {rem_q[k-1], low_q[k-1][QW-1]};
			diff = cur - {1'b0, den_q[k-1]};
			ge   = (cur >= {1'b0, den_q[k-1]});
		end

		always_ff @(posedge clk) begin
			quo_q[k] <= {prev_quo[QW-2:0], ge};
			ovf_q[k] <= ovf_q[k-1];
		end

		if (k < QW) begin : g_carry
			always_ff @(posedge clk) begin
				rem_q[k] <= ge ? diff[DD-1:0] : cur[DD-1:0];
				den_q[k] <= den_q[k-1];
				low_q[k] <= {low_q[k-1][QW-2:0], 1'b0};
			end
		end
	end

	assign quo = quo_q[QW];
	assign ovf = ovf_q[QW];

endmodule
